### hw/rtl/audio_peak_led_envelope_macros.svh
// Assertion macros shared by the envelope follower RTL.
// Each macro checks a clocked implication on clk with rst as disable.
`ifndef AUDIO_PEAK_LED_ENVELOPE_MACROS_SVH
`define AUDIO_PEAK_LED_ENVELOPE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define APLED_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define APLED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/apled_pkg.sv
// Package for the audio peak LED envelope follower.
// Holds item codes, register indexes and shared structs; no dependencies.
`timescale 1ns / 1ps

package apled_pkg;

  localparam logic [1:0] MODE_PEAK  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [1:0] REG_DECAY_STEP     = 2'd0;
  localparam logic [1:0] REG_MAX_BRIGHTNESS = 2'd1;
  localparam logic [1:0] REG_ACTIVE_LOW     = 2'd2;

  localparam logic [7:0] DECAY_STEP_RESET     = 8'd4;
  localparam logic [7:0] MAX_BRIGHTNESS_RESET = 8'd255;

  typedef struct packed {
    logic [7:0] decay_step;
    logic [7:0] max_brightness;
    logic       active_low;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] peak_level;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] envelope_level;
    logic       modulator_enable;
    logic [7:0] density_target;
    logic       pin_level;
    logic       capture_armed_out;
  } result_t;

endpackage

### hw/rtl/apled_if.sv
// Stream interfaces for the input items and the result items.
// Standalone; carries valid, ready and the payload fields.
`timescale 1ns / 1ps

interface apled_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] peak_level;

  modport source(output valid, mode, peak_level, input ready);
  modport sink(input valid, mode, peak_level, output ready);
endinterface

interface apled_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] brightness;
  logic [7:0] envelope_level;
  logic       modulator_enable;
  logic [7:0] density_target;
  logic       pin_level;
  logic       capture_armed_out;

  modport source(output valid, brightness, envelope_level, modulator_enable,
                 density_target, pin_level, capture_armed_out, input ready);
  modport sink(input valid, brightness, envelope_level, modulator_enable,
               density_target, pin_level, capture_armed_out, output ready);
endinterface

### hw/rtl/audio_peak_led_envelope.sv
// Top level of the audio peak LED envelope follower.
// Instantiates apled_regs, apled_in_stage and apled_core; uses apled_pkg and apled_if.
//
//   channel  | direction | handshake     | payload
//   sample   | in        | valid/ready   | mode, peak_level
//   result   | out       | valid/ready   | brightness, envelope_level, modulator_enable,
//            |           |               | density_target, pin_level, capture_armed_out
//   apb      | in        | psel/penable  | paddr, pwdata, prdata (pready tied high)
//
// One beat per cycle sustained while the result channel is ready; a result passes through
// the input register and then the result register, with the combinational update
// between them.
// Reset is synchronous and active high; it restores register defaults and the state.
// A stalled result register holds its beat while the input register still takes one
// more; the sample channel then waits until the result is taken.
`timescale 1ns / 1ps

module audio_peak_led_envelope
  import apled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  apled_in_if.sink    sample,
  apled_out_if.source result
);

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  apled_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apled_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .advance (advance),
    .stage   (stage)
  );

  apled_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .stage   (stage),
    .advance (advance),
    .result  (result)
  );

endmodule

### hw/rtl/apled_regs.sv
// APB-style configuration registers of the envelope follower.
// Uses apled_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module apled_regs
  import apled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_step     <= DECAY_STEP_RESET;
      cfg.max_brightness <= MAX_BRIGHTNESS_RESET;
      cfg.active_low     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_DECAY_STEP:     cfg.decay_step     <= pwdata[7:0];
        REG_MAX_BRIGHTNESS: cfg.max_brightness <= pwdata[7:0];
        REG_ACTIVE_LOW:     cfg.active_low     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_DECAY_STEP:     prdata = {24'd0, cfg.decay_step};
      REG_MAX_BRIGHTNESS: prdata = {24'd0, cfg.max_brightness};
      REG_ACTIVE_LOW:     prdata = {31'd0, cfg.active_low};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

### hw/rtl/apled_in_stage.sv
// Input register of the envelope follower: holds one accepted beat.
// Uses apled_pkg and the apled_in_if interface.
`timescale 1ns / 1ps

module apled_in_stage
  import apled_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  apled_in_if.sink  sample,
  input  logic      advance,
  output stage_t    stage
);

  logic take;

  assign sample.ready = !stage.valid || advance;
  assign take         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (take) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
    if (take) begin
      stage.item.mode       <= sample.mode;
      stage.item.peak_level <= sample.peak_level;
    end
  end

endmodule

### hw/rtl/apled_core.sv
// Envelope state update and result register of the envelope follower.
// Uses apled_pkg, apled_out_if and the assertion macros header.
`timescale 1ns / 1ps
`include "audio_peak_led_envelope_macros.svh"

module apled_core
  import apled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  stage_t      stage,
  output logic        advance,
  apled_out_if.source result
);

  logic [15:0] pending_peak, pending_peak_next;
  logic        reset_request, reset_request_next;
  logic        capture_armed, capture_armed_next;
  logic [7:0]  envelope, envelope_next;
  logic [7:0]  applied_brightness, applied_brightness_next;

  logic        res_valid;
  result_t     res_data, res_data_next;

  logic [23:0] peak_scaled;
  logic [24:0] peak_round;
  logic [8:0]  target_wide;
  logic [7:0]  target;
  logic [7:0]  env_base;
  logic [7:0]  env_rel;
  logic [7:0]  env_tick;
  logic [15:0] scale_mult;
  logic [16:0] scale_sum;
  logic [16:0] scale_quot;
  logic [7:0]  bright_tick;
  logic        modulate;

  assign advance = stage.valid && (!res_valid || result.ready);

  always_comb begin
    peak_scaled = {pending_peak, 8'd0} - {8'd0, pending_peak};
    peak_round  = {1'b0, peak_scaled} + 25'd16384;
    target_wide = peak_round[23:15];
    target      = target_wide[8] ? 8'hFF : target_wide[7:0];

    env_base = reset_request ? 8'd0 : envelope;
    env_rel  = (env_base > cfg.decay_step) ? (env_base - cfg.decay_step) : 8'd0;
    if (target >= env_base) begin
      env_tick = target;
    end else begin
      env_tick = (env_rel > target) ? env_rel : target;
    end

    scale_mult  = {8'd0, env_tick} * {8'd0, cfg.max_brightness};
    scale_sum   = {1'b0, scale_mult} + 17'd127;
    scale_quot  = scale_sum + 17'd1 + {8'd0, scale_sum[16:8]};
    bright_tick = scale_quot[15:8];
  end

  always_comb begin
    pending_peak_next       = pending_peak;
    reset_request_next      = reset_request;
    capture_armed_next      = capture_armed;
    envelope_next           = envelope;
    applied_brightness_next = applied_brightness;
    if (advance) begin
      unique case (stage.item.mode)
        MODE_PEAK: begin
          if (capture_armed) begin
            if (stage.item.peak_level > pending_peak) begin
              pending_peak_next = stage.item.peak_level;
            end
            capture_armed_next = 1'b0;
          end
        end
        MODE_CLEAR: begin
          pending_peak_next  = 16'd0;
          reset_request_next = 1'b1;
        end
        MODE_TICK: begin
          pending_peak_next       = 16'd0;
          reset_request_next      = 1'b0;
          capture_armed_next      = cfg.max_brightness != 8'd0;
          envelope_next           = env_tick;
          applied_brightness_next = bright_tick;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    modulate = (applied_brightness_next != 8'd0) && (applied_brightness_next != 8'hFF);
    res_data_next.brightness        = applied_brightness_next;
    res_data_next.envelope_level    = envelope_next;
    res_data_next.modulator_enable  = modulate;
    res_data_next.capture_armed_out = capture_armed_next;
    if (modulate) begin
      res_data_next.density_target = cfg.active_low ? (8'd0 - applied_brightness_next)
                                                    : applied_brightness_next;
      res_data_next.pin_level      = 1'b0;
    end else begin
      res_data_next.density_target = 8'd0;
      res_data_next.pin_level      = cfg.active_low ^ (applied_brightness_next != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_peak       <= 16'd0;
      reset_request      <= 1'b0;
      capture_armed      <= 1'b1;
      envelope           <= 8'd0;
      applied_brightness <= 8'd0;
      res_valid          <= 1'b0;
    end else begin
      pending_peak       <= pending_peak_next;
      reset_request      <= reset_request_next;
      capture_armed      <= capture_armed_next;
      envelope           <= envelope_next;
      applied_brightness <= applied_brightness_next;
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= res_data_next;
    end
  end

  assign result.valid             = res_valid;
  assign result.brightness        = res_data.brightness;
  assign result.envelope_level    = res_data.envelope_level;
  assign result.modulator_enable  = res_data.modulator_enable;
  assign result.density_target    = res_data.density_target;
  assign result.pin_level         = res_data.pin_level;
  assign result.capture_armed_out = res_data.capture_armed_out;

  `APLED_ASSERT_NEXT(a_tick_rearms, advance && (stage.item.mode == MODE_TICK) && (cfg.max_brightness != 8'd0), capture_armed, "tick with nonzero maximum did not re-arm capture")
  `APLED_ASSERT_NEXT(a_peak_disarms, advance && (stage.item.mode == MODE_PEAK), !capture_armed, "peak beat left capture armed")
  `APLED_ASSERT_NEXT(a_env_idle_hold, !advance, $stable(envelope) && $stable(pending_peak), "state changed without a beat")
  `APLED_ASSERT_NEXT(a_dark_at_zero_max, advance && (stage.item.mode == MODE_TICK) && (cfg.max_brightness == 8'd0), applied_brightness == 8'd0, "zero maximum gave nonzero brightness")
  `APLED_ASSERT_SAME(a_stall_blocks, stage.valid && res_valid && !result.ready, !advance, "stage advanced into an occupied result register")

endmodule

### verif/tb_audio_peak_led_envelope.sv
// Self-checking testbench for the audio peak LED envelope follower.
// Runs a directed table and then randomized phases, each with its own register settings;
// depends on apled_pkg, apled_if and the audio_peak_led_envelope RTL.
`timescale 1ns / 1ps

module tb_audio_peak_led_envelope;
  import apled_pkg::*;

  localparam int unsigned DIR_ROWS = 22;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 216;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 40;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam result_t DARK_ARMED = '{8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b1};
  localparam result_t DARK_HELD  = '{8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0};
  localparam result_t FULL_ON    = '{8'd255, 8'd255, 1'b0, 8'd0, 1'b1, 1'b1};

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] peak;
    logic        pinned;
    result_t     res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  apled_in_if  sample_if();
  apled_out_if result_if();

  audio_peak_led_envelope dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .sample (sample_if),
    .result (result_if)
  );

  // Model state and register shadow.
  logic [7:0]  cfg_decay;
  logic [7:0]  cfg_max;
  logic        cfg_active_low;
  logic [15:0] pend_peak;
  logic        pend_reset;
  logic        armed;
  logic [7:0]  env;
  logic [7:0]  bright;

  result_t     led_due[$];
  dir_row_t    dir_rows[DIR_ROWS];

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned beats_sent;
  bit          drain_stuck;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic result_t follow_envelope(input logic [1:0] m, input logic [15:0] p);
    result_t     r;
    logic [31:0] tgt;
    logic [31:0] rel;
    logic [31:0] prod;
    case (m)
      MODE_PEAK: begin
        if (armed) begin
          if (p > pend_peak) pend_peak = p;
          armed = 1'b0;
        end
      end
      MODE_CLEAR: begin
        pend_peak = 16'd0;
        pend_reset = 1'b1;
      end
      MODE_TICK: begin
        tgt = (32'(pend_peak) * 32'd255 + 32'd16384) >> 15;
        if (tgt > 32'd255) tgt = 32'd255;
        pend_peak = 16'd0;
        if (pend_reset) env = 8'd0;
        pend_reset = 1'b0;
        armed = (cfg_max != 8'd0);
        if (tgt >= 32'(env)) begin
          env = tgt[7:0];
        end else begin
          rel = (env > cfg_decay) ? 32'(env) - 32'(cfg_decay) : 32'd0;
          env = (rel > tgt) ? rel[7:0] : tgt[7:0];
        end
        prod = 32'(env) * 32'(cfg_max) + 32'd127;
        bright = 8'((prod + 32'd1 + (prod >> 8)) >> 8);
      end
      default: begin
      end
    endcase
    r.brightness = bright;
    r.envelope_level = env;
    r.modulator_enable = (bright != 8'd0) && (bright != 8'd255);
    if (r.modulator_enable) begin
      r.density_target = cfg_active_low ? 8'(9'd256 - 9'(bright)) : bright;
      r.pin_level = 1'b0;
    end else begin
      r.density_target = 8'd0;
      r.pin_level = (bright != 8'd0) ^ cfg_active_low;
    end
    r.capture_armed_out = armed;
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] m, input logic [15:0] p, input logic pinned,
                           input result_t pinned_res);
    result_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.mode <= m;
    sample_if.peak_level <= p;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    predicted = follow_envelope(m, p);
    led_due.push_back(pinned ? pinned_res : predicted);
    beats_sent++;
  endtask

  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    sample_if.valid <= 1'b0;
    while (led_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (led_due.size() != 0) drain_stuck = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DECAY_STEP:     cfg_decay = value;
      REG_MAX_BRIGHTNESS: cfg_max = value;
      REG_ACTIVE_LOW:     cfg_active_low = value[0];
      default: begin
      end
    endcase
  endtask

  function automatic logic [15:0] pick_peak();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom());
      1: v = 16'($urandom_range(0, 2047));
      2: begin
        case ($urandom_range(0, 3))
          0: v = 16'h0000;
          1: v = 16'hFFFF;
          2: v = 16'h8000;
          default: v = 16'h7FFF;
        endcase
      end
      default: v = 16'($urandom_range(32768, 65535));
    endcase
    return v;
  endfunction

  task automatic cmp_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (led_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: result beat expected none actual brightness %0d", $time,
                 result_if.brightness);
    end else begin
      want = led_due.pop_front();
      results_seen++;
      cmp_field("brightness", want.brightness, result_if.brightness);
      cmp_field("envelope_level", want.envelope_level, result_if.envelope_level);
      cmp_field("modulator_enable", want.modulator_enable, result_if.modulator_enable);
      cmp_field("density_target", want.density_target, result_if.density_target);
      cmp_field("pin_level", want.pin_level, result_if.pin_level);
      cmp_field("capture_armed_out", want.capture_armed_out, result_if.capture_armed_out);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) check_result();
    result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("Run did not finish in the allowed time.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned counted;
    int unsigned phase;
    int unsigned pick;
    logic [7:0]  d_set;
    logic [7:0]  m_set;
    logic        a_set;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 4'd0;
    pwdata <= 32'd0;
    sample_if.valid <= 1'b0;
    sample_if.mode <= MODE_PEAK;
    sample_if.peak_level <= 16'd0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    results_seen = 0;
    beats_sent = 0;
    drain_stuck = 1'b0;

    cfg_decay = DECAY_STEP_RESET;
    cfg_max = MAX_BRIGHTNESS_RESET;
    cfg_active_low = 1'b0;
    pend_peak = 16'd0;
    pend_reset = 1'b0;
    armed = 1'b1;
    env = 8'd0;
    bright = 8'd0;

    dir_rows[0]  = '{MODE_UNUSED, 16'hFFFF, 1'b1, DARK_ARMED};
    dir_rows[1]  = '{MODE_PEAK,  16'hFFFF, 1'b1, DARK_HELD};
    dir_rows[2]  = '{MODE_PEAK,  16'h0000, 1'b1, DARK_HELD};
    dir_rows[3]  = '{MODE_TICK,  16'h0000, 1'b1, FULL_ON};
    dir_rows[4]  = '{MODE_TICK,  16'h1234, 1'b0, '0};
    dir_rows[5]  = '{MODE_TICK,  16'h0000, 1'b0, '0};
    dir_rows[6]  = '{MODE_CLEAR, 16'hFFFF, 1'b0, '0};
    dir_rows[7]  = '{MODE_TICK,  16'h0000, 1'b1, DARK_ARMED};
    dir_rows[8]  = '{MODE_PEAK,  16'h4000, 1'b1, DARK_HELD};
    dir_rows[9]  = '{MODE_TICK,  16'h0000, 1'b0, '0};
    dir_rows[10] = '{MODE_PEAK,  16'h8000, 1'b0, '0};
    dir_rows[11] = '{MODE_TICK,  16'h0000, 1'b0, '0};
    dir_rows[12] = '{MODE_PEAK,  16'h0001, 1'b0, '0};
    dir_rows[13] = '{MODE_TICK,  16'h0000, 1'b0, '0};
    dir_rows[14] = '{MODE_PEAK,  16'h8001, 1'b0, '0};
    dir_rows[15] = '{MODE_CLEAR, 16'h0000, 1'b0, '0};
    dir_rows[16] = '{MODE_TICK,  16'h0000, 1'b1, DARK_ARMED};
    dir_rows[17] = '{MODE_PEAK,  16'hAAAA, 1'b0, '0};
    dir_rows[18] = '{MODE_PEAK,  16'h5555, 1'b0, '0};
    dir_rows[19] = '{MODE_TICK,  16'h0000, 1'b0, '0};
    dir_rows[20] = '{MODE_UNUSED, 16'h5555, 1'b0, '0};
    dir_rows[21] = '{MODE_TICK,  16'h0000, 1'b0, '0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(dir_rows[i].mode, dir_rows[i].peak, dir_rows[i].pinned, dir_rows[i].res);
    drain_results();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin d_set = 8'd0;   m_set = 8'd255; a_set = 1'b0; end
        1: begin d_set = 8'd255; m_set = 8'd255; a_set = 1'b1; end
        2: begin d_set = 8'd4;   m_set = 8'd0;   a_set = 1'b0; end
        3: begin d_set = 8'd1;   m_set = 8'd128; a_set = 1'b1; end
        4: begin d_set = 8'd255; m_set = 8'd1;   a_set = 1'b0; end
        7: begin d_set = 8'd0;   m_set = 8'd0;   a_set = 1'b1; end
        default: begin
          d_set = 8'($urandom_range(0, 255));
          m_set = 8'($urandom_range(1, 255));
          a_set = 1'($urandom_range(0, 1));
        end
      endcase
      apb_write(REG_DECAY_STEP, d_set);
      apb_write(REG_MAX_BRIGHTNESS, m_set);
      apb_write(REG_ACTIVE_LOW, {7'd0, a_set});

      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 68; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 68; end
        default: begin send_gap_pct = 12; recv_stall_pct = 12; end
      endcase

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // Well-formed burst: one or more peaks, then the tick that consumes them.
          repeat ($urandom_range(1, 3)) begin
            send_beat(MODE_PEAK, pick_peak(), 1'b0, '0);
            counted++;
          end
          send_beat(MODE_TICK, 16'($urandom()), 1'b0, '0);
          counted++;
        end else if (pick < 85) begin
          send_beat(MODE_CLEAR, 16'($urandom()), 1'b0, '0);
          counted++;
          if ($urandom_range(0, 1) == 1) begin
            send_beat(MODE_TICK, 16'($urandom()), 1'b0, '0);
            counted++;
          end
        end else if (pick < 95) begin
          send_beat(2'($urandom_range(0, 2)), pick_peak(), 1'b0, '0);
          counted++;
        end else begin
          send_beat(MODE_UNUSED, 16'($urandom()), 1'b0, '0);
          counted++;
        end
        if (counted >= ITEMS_PER_PHASE / 2 && counted < ITEMS_PER_PHASE / 2 + 4 &&
            led_due.size() != 0)
          drain_results();
      end
      drain_results();
    end

    send_gap_pct = 0;
    drain_results();
    if (drain_stuck) begin
      $display("Results stopped arriving with %0d still outstanding.", led_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      $display("Checked %0d results from %0d beats over %0d register settings,",
               results_seen, beats_sent, PHASES + 1);
      $display("with no idling, sender gaps, receiver stalls and both mixed.");
      if (mismatches == 0 && led_due.size() == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("%0d field mismatches, %0d results outstanding.", mismatches,
                 led_due.size());
        $display("SCOREBOARD MISMATCH");
      end
      $finish;
    end
  end

endmodule
